[rtl/core/pinyin_utf8_to_keypad_digits_macros.svh]
// Assertion macros shared by the pinyin keypad decoder modules
`ifndef PINYIN_UTF8_TO_KEYPAD_DIGITS_MACROS_SVH
`define PINYIN_UTF8_TO_KEYPAD_DIGITS_MACROS_SVH

`ifndef ASSERT_OFF

`define PYT9_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pyt9 assertion failed");

`define PYT9_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pyt9 implication failed");

`define PYT9_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pyt9 next-cycle check failed");

`else

`define PYT9_ASSERT(lbl, prop)
`define PYT9_ASSERT_IMPL(lbl, ante, cons)
`define PYT9_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/pyt9_pkg.sv]
// Shared types, constants and character functions for the pinyin keypad decoder
package pyt9_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'h3F;

  localparam logic [6:0] CharSpace = 7'h20;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusSpace = 2'd2;

  typedef enum logic [0:0] {
    KindChar = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  // queue word: a finished code point, or the tail of a string to decode
  typedef struct packed {
    kind_e            kind;
    logic [20:0]      cp;
    logic [3:0][7:0]  seq;
    logic [2:0]       n;
  } word_t;

  // sequence length from a lead byte, 0 when not a valid lead
  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (!b[7]) begin
      len = 3'd1;
    end else if ((b & Lead2Mask) == Lead2Tag) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // payload bits of a lead byte
  function automatic logic [20:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
    logic [20:0] v;
    case (len)
      3'd2:    v = {16'd0, b[4:0]};
      3'd3:    v = {17'd0, b[3:0]};
      3'd4:    v = {18'd0, b[2:0]};
      default: v = {13'd0, b};
    endcase
    return v;
  endfunction

  function automatic logic [6:0] tone_plain(input logic [20:0] cp);
    logic [6:0] ch;
    case (cp)
      21'h000101, 21'h0001CE, 21'h0000E1, 21'h0000E0,
      21'h000100, 21'h0001CD, 21'h0000C1, 21'h0000C0: ch = 7'h61; // a
      21'h000113, 21'h00011B, 21'h0000E9, 21'h0000E8,
      21'h000112, 21'h00011A, 21'h0000C9, 21'h0000C8: ch = 7'h65; // e
      21'h00012B, 21'h0001D0, 21'h0000ED, 21'h0000EC,
      21'h00012A, 21'h0001CF, 21'h0000CD, 21'h0000CC: ch = 7'h69; // i
      21'h00014D, 21'h0001D2, 21'h0000F3, 21'h0000F2,
      21'h00014C, 21'h0001D1, 21'h0000D3, 21'h0000D2: ch = 7'h6F; // o
      21'h00016B, 21'h0001D4, 21'h0000FA, 21'h0000F9,
      21'h00016A, 21'h0001D3, 21'h0000DA, 21'h0000D9: ch = 7'h75; // u
      21'h0001D6, 21'h0001D8, 21'h0001DA, 21'h0001DC, 21'h0000FC,
      21'h0001D5, 21'h0001D7, 21'h0001D9, 21'h0001DB, 21'h0000DC: ch = 7'h76; // v
      21'h000144, 21'h000148, 21'h0001F9,
      21'h000143, 21'h000147, 21'h0001F8: ch = 7'h6E; // n
      21'h001E3F, 21'h001E3E: ch = 7'h6D; // m
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

  // kept character for a code point, 0 when dropped
  function automatic logic [6:0] normalize(input logic [20:0] cp);
    logic [6:0] ch;
    if (cp inside {[21'h61:21'h7A]}) begin
      ch = cp[6:0];
    end else if (cp inside {[21'h41:21'h5A]}) begin
      ch = cp[6:0] + 7'd32;
    end else if (cp == {14'd0, CharSpace}) begin
      ch = CharSpace;
    end else if (cp < 21'h80) begin
      ch = 7'd0;
    end else begin
      ch = tone_plain(cp);
    end
    return ch;
  endfunction

  function automatic logic [3:0] key_of(input logic [6:0] ch);
    logic [3:0] k;
    if (ch inside {[7'h61:7'h63]}) begin
      k = 4'd2;
    end else if (ch inside {[7'h64:7'h66]}) begin
      k = 4'd3;
    end else if (ch inside {[7'h67:7'h69]}) begin
      k = 4'd4;
    end else if (ch inside {[7'h6A:7'h6C]}) begin
      k = 4'd5;
    end else if (ch inside {[7'h6D:7'h6F]}) begin
      k = 4'd6;
    end else if (ch inside {[7'h70:7'h73]}) begin
      k = 4'd7;
    end else if (ch inside {[7'h74:7'h76]}) begin
      k = 4'd8;
    end else if (ch inside {[7'h77:7'h7A]}) begin
      k = 4'd9;
    end else begin
      k = 4'd0;
    end
    return k;
  endfunction

endpackage

[rtl/core/pinyin_utf8_to_keypad_digits.sv]
// Top level of the pinyin UTF-8 to keypad digit converter
//
// Input channel (in_valid_i/in_ready_o) takes one word per cycle: a raw byte of a
// UTF-8 pinyin string and in_last_i on its final byte. Output channel
// (out_valid_o/out_ready_i) gives one word per kept letter or space with its
// keypad digit; the final word of a string carries end_mark_o and status_o
// (ok, empty, space present). A string end with nothing kept still gives one
// word with has_char_o low.
// A byte's result is written into the queue and then into the output register.
// Throughput: one byte per cycle; a string end that yields two characters
// holds the back end while both words leave the output register. The front
// end decodes the byte stream, the back end normalizes and emits, and a
// QueueDepth-word queue between them absorbs stalls.
// When out_ready_i is low the output word holds and the queue fills; the
// input is refused only when the queue is full.
// Reset clears decode state, the queue and the output valid; no clearing
// pass is needed.
module pinyin_utf8_to_keypad_digits #(
  parameter int unsigned QueueDepth = pyt9_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_char_o,
  output logic [6:0] letter_o,
  output logic [3:0] key_digit_o,
  output logic       end_mark_o,
  output logic [1:0] status_o
);

  pyt9_pkg::word_t push_word, head_word;
  logic            push, q_ready, head_valid, pop;

  pyt9_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .word_o     (push_word)
  );

  pyt9_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_valid),
    .word_o  (head_word)
  );

  pyt9_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .has_char_o   (has_char_o),
    .letter_o     (letter_o),
    .key_digit_o  (key_digit_o),
    .end_mark_o   (end_mark_o),
    .status_o     (status_o)
  );

endmodule

[rtl/core/pyt9_front.sv]
// Byte front end: UTF-8 sequence tracking and queue word building
`include "pinyin_utf8_to_keypad_digits_macros.svh"

module pyt9_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output pyt9_pkg::word_t word_o
);

  logic [20:0]     acc_q, acc_d;
  logic [1:0]      need_q, need_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [7:0]      held_q [3];
  logic            held_we;
  logic [1:0]      held_idx;
  logic            fire;
  logic [2:0]      len;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign len        = pyt9_pkg::utf8_len(in_byte_i);

  always_comb begin
    acc_d    = acc_q;
    need_d   = need_q;
    cnt_d    = cnt_q;
    held_we  = 1'b0;
    held_idx = cnt_q;
    push_o   = 1'b0;
    word_o   = '0;
    if (fire) begin
      if (in_last_i) begin
        word_o.kind = pyt9_pkg::KindEnd;
        for (int i = 0; i < 3; i++) begin
          word_o.seq[i] = (2'(i) < cnt_q) ? held_q[i] : in_byte_i;
        end
        word_o.seq[3] = in_byte_i;
        word_o.n      = {1'b0, cnt_q} + 3'd1;
        push_o        = 1'b1;
        acc_d         = '0;
        need_d        = '0;
        cnt_d         = '0;
      end else if (need_q == 2'd0) begin
        case (len)
          3'd1: begin
            if (in_byte_i != 8'd0) begin
              word_o.kind = pyt9_pkg::KindChar;
              word_o.cp   = {13'd0, in_byte_i};
              push_o      = 1'b1;
            end
          end
          3'd2, 3'd3, 3'd4: begin
            need_d   = 2'(len - 3'd1);
            acc_d    = pyt9_pkg::lead_bits(in_byte_i, len);
            held_we  = 1'b1;
            held_idx = 2'd0;
            cnt_d    = 2'd1;
          end
          default: ;
        endcase
      end else begin
        acc_d  = {acc_q[14:0], in_byte_i[5:0]};
        need_d = need_q - 2'd1;
        if (cnt_q != 2'd3) begin
          held_we = 1'b1;
          cnt_d   = cnt_q + 2'd1;
        end
        if (need_d == 2'd0) begin
          word_o.kind = pyt9_pkg::KindChar;
          word_o.cp   = acc_d;
          push_o      = 1'b1;
          acc_d       = '0;
          cnt_d       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      need_q <= '0;
      cnt_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      need_q <= need_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[held_idx] <= in_byte_i;
    end
  end

  `PYT9_ASSERT_IMPL(a_need_has_lead, need_q != 2'd0, cnt_q != 2'd0)
  `PYT9_ASSERT_IMPL(a_idle_no_held, need_q == 2'd0, cnt_q == 2'd0)
  `PYT9_ASSERT_NEXT(a_last_clears, fire && in_last_i, need_q == 2'd0 && acc_q == 21'd0)

endmodule

[rtl/core/pyt9_fifo.sv]
// Word queue between the byte front end and the character back end
module pyt9_fifo #(
  parameter int unsigned Depth = pyt9_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pyt9_pkg::word_t word_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pyt9_pkg::word_t word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pyt9_pkg::word_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule

[rtl/core/pyt9_back.sv]
// Character back end: normalizing, end-of-string decode, status and output register
`include "pinyin_utf8_to_keypad_digits_macros.svh"

module pyt9_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  pyt9_pkg::word_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            has_char_o,
  output logic [6:0]      letter_o,
  output logic [3:0]      key_digit_o,
  output logic            end_mark_o,
  output logic [1:0]      status_o
);

  logic       out_vq;
  logic       has_q, has_d;
  logic [6:0] let_q, let_d;
  logic       end_q, end_d;
  logic [1:0] st_q, st_d;
  logic       phase_q, phase_d;
  logic       any_q, any_d;
  logic       space_q, space_d;
  logic       load, can_load;

  logic [2:0]  lens   [4];
  logic        fits   [4];
  logic [6:0]  chs    [4];
  logic [6:0]  c0, c1;
  logic [1:0]  m;
  logic [6:0]  ch_c;

  assign ch_c = pyt9_pkg::normalize(head_i.cp);

  // decode of the string tail: up to four bytes, first two kept characters
  always_comb begin
    logic [20:0] cpv;
    logic [2:0]  pos;
    cpv = '0;
    pos = '0;
    for (int p = 0; p < 4; p++) begin
      lens[p] = pyt9_pkg::utf8_len(head_i.seq[p]);
      fits[p] = (lens[p] != 3'd0) && ((3'(p) + lens[p]) <= head_i.n);
      cpv     = pyt9_pkg::lead_bits(head_i.seq[p], lens[p]);
      for (int j = 1; j < 4; j++) begin
        if ((p + j < 4) && (3'(j) < lens[p])) begin
          cpv = {cpv[14:0], head_i.seq[2'(p + j)][5:0]};
        end
      end
      chs[p] = pyt9_pkg::normalize(cpv);
    end
    c0 = '0;
    c1 = '0;
    m  = '0;
    for (int s = 0; s < 4; s++) begin
      if (pos < head_i.n) begin
        if (fits[pos[1:0]]) begin
          if (chs[pos[1:0]] != 7'd0) begin
            if (m == 2'd0) begin
              c0 = chs[pos[1:0]];
            end else if (m == 2'd1) begin
              c1 = chs[pos[1:0]];
            end
            if (m != 2'd2) begin
              m = m + 2'd1;
            end
          end
          pos = pos + lens[pos[1:0]];
        end else begin
          pos = pos + 3'd1;
        end
      end
    end
  end

  assign can_load = !out_vq || out_ready_i;

  always_comb begin
    logic [6:0] pick;
    logic       has_e, any_e, sp_e;
    pick    = phase_q ? c1 : c0;
    has_e   = (m != 2'd0);
    any_e   = any_q || has_e;
    sp_e    = space_q || (has_e && pick == pyt9_pkg::CharSpace);
    pop_o   = 1'b0;
    load    = 1'b0;
    phase_d = phase_q;
    any_d   = any_q;
    space_d = space_q;
    has_d   = has_q;
    let_d   = let_q;
    end_d   = end_q;
    st_d    = st_q;
    if (head_valid_i && can_load) begin
      case (head_i.kind)
        pyt9_pkg::KindChar: begin
          pop_o = 1'b1;
          if (ch_c != 7'd0) begin
            load    = 1'b1;
            has_d   = 1'b1;
            let_d   = ch_c;
            end_d   = 1'b0;
            st_d    = pyt9_pkg::StatusOk;
            any_d   = 1'b1;
            space_d = space_q || (ch_c == pyt9_pkg::CharSpace);
          end
        end
        pyt9_pkg::KindEnd: begin
          load  = 1'b1;
          has_d = has_e;
          let_d = has_e ? pick : 7'd0;
          if (m == 2'd2 && !phase_q) begin
            end_d   = 1'b0;
            st_d    = pyt9_pkg::StatusOk;
            phase_d = 1'b1;
            any_d   = 1'b1;
            space_d = sp_e;
          end else begin
            pop_o   = 1'b1;
            end_d   = 1'b1;
            st_d    = !any_e ? pyt9_pkg::StatusEmpty :
                      (sp_e ? pyt9_pkg::StatusSpace : pyt9_pkg::StatusOk);
            phase_d = 1'b0;
            any_d   = 1'b0;
            space_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      phase_q <= 1'b0;
      any_q   <= 1'b0;
      space_q <= 1'b0;
    end else begin
      out_vq  <= load ? 1'b1 : (out_ready_i ? 1'b0 : out_vq);
      phase_q <= phase_d;
      any_q   <= any_d;
      space_q <= space_d;
    end
  end

  always_ff @(posedge clk_i) begin
    has_q <= has_d;
    let_q <= let_d;
    end_q <= end_d;
    st_q  <= st_d;
  end

  assign out_valid_o = out_vq;
  assign has_char_o  = has_q;
  assign letter_o    = let_q;
  assign key_digit_o = pyt9_pkg::key_of(let_q);
  assign end_mark_o  = end_q;
  assign status_o    = st_q;

  `PYT9_ASSERT_IMPL(a_phase_on_pair, phase_q, head_valid_i && head_i.kind == pyt9_pkg::KindEnd && m == 2'd2)
  `PYT9_ASSERT_IMPL(a_empty_is_end, out_vq && !has_q, end_q)
  `PYT9_ASSERT_IMPL(a_status_on_end, out_vq && st_q != pyt9_pkg::StatusOk, end_q)

endmodule
